@@ design/led_fire_heat_update_assert.svh @@
// ----------------------------------------------------------------------------
// led_fire_heat_update_assert.svh
// Assertion macros used by the fire heat update top-level design file.
// ----------------------------------------------------------------------------
`ifndef LED_FIRE_HEAT_UPDATE_ASSERT_SVH
`define LED_FIRE_HEAT_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle property, checked outside reset
`define LFH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent this cycle, consequent on the next cycle
`define LFH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define LFH_ASSERT(lbl, clk, rst_n, prop, msg)
`define LFH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/lfh_pkg.sv @@
// ----------------------------------------------------------------------------
// lfh_pkg
// Widths, register indexes and arithmetic constants of the fire heat update.
// ----------------------------------------------------------------------------
package lfh_pkg;

    // Field widths
    localparam int HEAT_W     = 8;
    localparam int RAND_W     = 8;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int COOL_W     = 6;
    localparam int NUM_W      = 10;
    localparam int OUT_IDX_W  = 9;

    typedef logic [HEAT_W-1:0] heat_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARK_THRESHOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLING_INTENSITY = 2'd2;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] SEGMENT_LENGTH_RST    = 10'd300;
    localparam logic [HEAT_W-1:0]     SPARK_THRESHOLD_RST   = 8'd120;
    localparam logic [HEAT_W-1:0]     COOLING_INTENSITY_RST = 8'd55;

    // Cooling: intensity of zero falls back to this value
    localparam logic [COOL_W-1:0] COOL_DEFAULT = 6'd55;
    localparam logic [3:0]        COOL_SCALE   = 4'd10;
    localparam logic [1:0]        BOUND_BIAS   = 2'd2;
    localparam logic [HEAT_W-1:0] BOUND_MAX    = 8'd255;
    localparam logic [HEAT_W-1:0] HEAT_MAX     = 8'd255;

    // Spark placement and heat
    localparam logic [2:0]        SPARK_SPAN  = 3'd7;
    localparam logic [HEAT_W-1:0] SPARK_BASE  = 8'd160;
    localparam logic [6:0]        SPARK_RANGE = 7'd95;

    // Divide by three: x * 683 >> 11, exact for x below 2048
    localparam logic [9:0] DRIFT_RECIP = 10'd683;
    localparam int         DRIFT_SHIFT = 11;

    // Palette scale
    localparam logic [HEAT_W-1:0] COLOR_SCALE = 8'd241;

endpackage

@@ design/lfh_heat_ram.sv @@
// ----------------------------------------------------------------------------
// lfh_heat_ram
// Heat store: one write port, one registered read port, old data on a
// read of the address being written.
// ----------------------------------------------------------------------------
module lfh_heat_ram
    import lfh_pkg::*;
#(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output heat_t             rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  heat_t             wr_data
);

    heat_t mem [DEPTH];
    heat_t rd_data_reg;

    // Storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/lfh_bound_div.sv @@
// ----------------------------------------------------------------------------
// lfh_bound_div
// Cooling bound: min(255, numer / divisor + 2), restoring division one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfh_bound_div
    import lfh_pkg::*;
#(
    parameter int LEN_W = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [LEN_W-1:0] divisor,
    output logic             busy,
    output heat_t            bound
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [LEN_W-1:0] den_reg;
    logic [LEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quot_reg;
    heat_t            bound_reg;

    logic [LEN_W:0]   trial;
    logic             take;
    logic [LEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quot_next;
    logic [NUM_W:0]   sum;
    heat_t            bound_next;
    logic             last_step;

    // One restoring step
    always_comb
    begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        take      = (trial >= {1'b0, den_reg});
        rem_next  = take ? LEN_W'(trial - {1'b0, den_reg}) : LEN_W'(trial);
        quot_next = {quot_reg[NUM_W-2:0], take};
        sum       = (NUM_W+1)'(quot_next) + (NUM_W+1)'(BOUND_BIAS);
        bound_next = (sum > (NUM_W+1)'(BOUND_MAX)) ? BOUND_MAX : sum[HEAT_W-1:0];
        last_step = (cnt_reg == CNT_W'(NUM_W - 1));
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= numer;
            den_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            if (last_step)
            begin
                bound_reg <= bound_next;
            end
        end
    end

    assign busy  = busy_reg;
    assign bound = bound_reg;

endmodule

@@ design/led_fire_heat_update.sv @@
// ----------------------------------------------------------------------------
// led_fire_heat_update
// Fire heat simulation over an LED strip, one cell per transfer.
//
// Input channel (in_valid/in_ready): one transfer per cell, top cell first,
// frame_start set on the top cell. Output channel (out_valid/out_ready): one
// result per input, in order, with the new heat and palette index.
// Configuration: cfg_we writes cfg_data into the register at cfg_index.
// Each result passes the stage 1 registers and then the output register.
// Throughput: one cell per cycle while the receiver keeps up and no sweep or
// division runs; the heat store takes one read and one write per cell, and
// a same-cell hazard is forwarded. After reset the heat store is swept to
// zero and the cooling bound is divided out; in_ready stays low meanwhile.
// After a configuration write the bound is recomputed.
// A frame start with clear_heat waits for stage 1 to drain and then a sweep
// of the heat store before it is taken.
// When the receiver stalls, the output register holds its result and one
// more cell is taken into the compute stage before in_ready drops.
// ----------------------------------------------------------------------------
`include "led_fire_heat_update_assert.svh"

module led_fire_heat_update
    import lfh_pkg::*;
#(
    parameter int MAX_CELLS = 512
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // cell input
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [RAND_W-1:0]     cool_random,
    input  logic [RAND_W-1:0]     spark_roll,
    input  logic [RAND_W-1:0]     spark_offset_random,
    input  logic [RAND_W-1:0]     spark_heat_random,
    input  logic                  frame_start,
    input  logic                  clear_heat,
    // cell result
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_IDX_W-1:0]  cell_index,
    output heat_t                 heat_value,
    output heat_t                 color_index,
    output logic                  last_of_frame
);

    localparam int IDX_W = $clog2(MAX_CELLS);
    localparam int LEN_W = $clog2(MAX_CELLS + 1);
    localparam int LW1   = LEN_W + 1;

    // Configuration registers
    logic [CFG_DATA_W-1:0] segment_length_reg;
    heat_t                 spark_threshold_reg;
    heat_t                 cooling_intensity_reg;
    logic                  div_pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_length_reg    <= SEGMENT_LENGTH_RST;
            spark_threshold_reg   <= SPARK_THRESHOLD_RST;
            cooling_intensity_reg <= COOLING_INTENSITY_RST;
            div_pending_reg       <= 1'b1;
        end
        else
        begin
            div_pending_reg <= cfg_we;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SEGMENT_LENGTH:    segment_length_reg    <= cfg_data;
                    CFG_SPARK_THRESHOLD:   spark_threshold_reg   <= cfg_data[HEAT_W-1:0];
                    CFG_COOLING_INTENSITY: cooling_intensity_reg <= cfg_data[HEAT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Active length, clamped to 1..MAX_CELLS
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] len_m1;

    always_comb
    begin
        if (segment_length_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (32'(segment_length_reg) > MAX_CELLS)
        begin
            len = LEN_W'(MAX_CELLS);
        end
        else
        begin
            len = LEN_W'(segment_length_reg);
        end
        len_m1 = len - 1'b1;
    end

    // Cooling bound, divided out after reset and after each config write
    logic [COOL_W-1:0] cooling;
    logic [NUM_W-1:0]  numer;
    logic              div_busy;
    heat_t             bound;

    assign cooling = (cooling_intensity_reg == '0) ? COOL_DEFAULT
                                                   : cooling_intensity_reg[HEAT_W-1:2];
    assign numer   = NUM_W'(cooling) * NUM_W'(COOL_SCALE);

    lfh_bound_div #(
        .LEN_W (LEN_W)
    ) u_bound_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_pending_reg),
        .numer   (numer),
        .divisor (len),
        .busy    (div_busy),
        .bound   (bound)
    );

    // Pipeline registers
    logic             s1_valid_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    heat_t            s1_cool_amt_reg;
    logic             s1_drift_reg;
    logic             s1_hit_reg;
    heat_t            s1_spark_amt_reg;
    logic             s1_clear_reg;
    logic             s1_bypass_reg;
    heat_t            s1_fwd_reg;

    logic             out_valid_reg;
    logic [IDX_W-1:0] out_idx_reg;
    heat_t            out_heat_reg;
    logic             out_last_reg;

    // Frame control state
    logic [IDX_W-1:0] cell_counter_reg;
    logic [IDX_W-1:0] spark_position_reg;
    logic             spark_armed_reg;
    heat_t            spark_amount_reg;
    logic             clearing_frame_reg;
    heat_t            cooled_above_one_reg;
    heat_t            cooled_above_two_reg;

    // Heat store sweep
    logic             sweep_active_reg;
    logic [IDX_W-1:0] sweep_addr_reg;
    logic             swept_reg;

    // Handshake
    logic busy;
    logic clr_hold;
    logic sweep_start;
    logic s2_take;
    logic s1_fire;
    logic in_fire;

    assign busy        = sweep_active_reg || div_pending_reg || div_busy;
    assign clr_hold    = in_valid && frame_start && clear_heat && !swept_reg;
    assign sweep_start = clr_hold && !sweep_active_reg && !s1_valid_reg;
    assign s2_take     = !out_valid_reg || out_ready;
    assign s1_fire     = s1_valid_reg && s2_take;
    assign in_ready    = !busy && !clr_hold && (!s1_valid_reg || s2_take);
    assign in_fire     = in_valid && in_ready;

    // Stage 0: cell index, spark arming, cooling amount
    logic [10:0]      off_prod;
    logic [2:0]       off;
    logic [14:0]      sheat_prod;
    heat_t            spark_amt_new;
    logic             spark_ok;
    logic [IDX_W-1:0] spark_pos_new;
    logic [IDX_W-1:0] idx;
    logic             armed_eff;
    logic [IDX_W-1:0] pos_eff;
    heat_t            amt_eff;
    logic             clear_eff;
    logic             hit;
    logic             drift;
    logic [15:0]      cool_prod;
    heat_t            cool_amt;
    logic [IDX_W-1:0] cell_counter_next;
    logic             bypass;

    always_comb
    begin
        off_prod      = 11'(spark_offset_random) * 11'(SPARK_SPAN);
        off           = off_prod[10:8];
        sheat_prod    = 15'(spark_heat_random) * 15'(SPARK_RANGE);
        spark_amt_new = SPARK_BASE + HEAT_W'(sheat_prod[14:8]);
        spark_ok      = (spark_roll < spark_threshold_reg) && (LEN_W'(off) <= len_m1);
        spark_pos_new = spark_ok ? (IDX_W'(len_m1) - IDX_W'(off)) : '0;

        idx       = frame_start ? IDX_W'(len_m1) : cell_counter_reg;
        armed_eff = frame_start ? spark_ok : spark_armed_reg;
        pos_eff   = frame_start ? spark_pos_new : spark_position_reg;
        amt_eff   = frame_start ? spark_amt_new : spark_amount_reg;
        clear_eff = frame_start ? clear_heat : clearing_frame_reg;
        hit       = armed_eff && (idx == pos_eff);

        // the top two cells take no drift
        drift = ((LW1'(idx) + LW1'(2)) < LW1'(len));

        cool_prod = 16'(cool_random) * 16'(bound);
        cool_amt  = cool_prod[15:8];

        cell_counter_next = (idx != '0) ? (idx - 1'b1) : '0;

        // cell still being written by stage 1 in this cycle
        bypass = s1_fire && (s1_idx_reg == idx);
    end

    // Stage 1: cool, drift, spark
    heat_t       ram_rdata;
    heat_t       s1_stored;
    heat_t       s1_cooled;
    logic [9:0]  drift_sum;
    logic [19:0] drift_prod;
    heat_t       s1_base;
    logic [8:0]  spark_sum;
    heat_t       s1_heat;

    always_comb
    begin
        if (s1_clear_reg)
        begin
            s1_stored = '0;
        end
        else if (s1_bypass_reg)
        begin
            s1_stored = s1_fwd_reg;
        end
        else
        begin
            s1_stored = ram_rdata;
        end
        s1_cooled = (s1_stored > s1_cool_amt_reg) ? (s1_stored - s1_cool_amt_reg) : '0;

        drift_sum  = 10'(cooled_above_one_reg) + {1'b0, cooled_above_two_reg, 1'b0};
        drift_prod = 20'(drift_sum) * 20'(DRIFT_RECIP);
        s1_base    = s1_drift_reg ? drift_prod[DRIFT_SHIFT+HEAT_W-1:DRIFT_SHIFT] : s1_cooled;

        spark_sum = 9'(s1_base) + 9'(s1_spark_amt_reg);
        if (s1_hit_reg)
        begin
            s1_heat = spark_sum[HEAT_W] ? HEAT_MAX : spark_sum[HEAT_W-1:0];
        end
        else
        begin
            s1_heat = s1_base;
        end
    end

    // Heat store
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    heat_t            ram_wdata;

    assign ram_we    = s1_fire || sweep_active_reg;
    assign ram_waddr = sweep_active_reg ? sweep_addr_reg : s1_idx_reg;
    assign ram_wdata = sweep_active_reg ? '0 : s1_heat;

    lfh_heat_ram #(
        .DEPTH  (MAX_CELLS),
        .ADDR_W (IDX_W)
    ) u_heat_ram (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (idx),
        .rd_data (ram_rdata),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata)
    );

    // Sweep sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_active_reg <= 1'b1;
            sweep_addr_reg   <= '0;
            swept_reg        <= 1'b0;
        end
        else
        begin
            if (sweep_active_reg)
            begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
                if (sweep_addr_reg == IDX_W'(MAX_CELLS - 1))
                begin
                    sweep_active_reg <= 1'b0;
                    sweep_addr_reg   <= '0;
                    swept_reg        <= 1'b1;
                end
            end
            else if (sweep_start)
            begin
                sweep_active_reg <= 1'b1;
            end
            if (in_fire)
            begin
                swept_reg <= 1'b0;
            end
        end
    end

    // Frame control state, advanced on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_counter_reg   <= '0;
            spark_position_reg <= '0;
            spark_armed_reg    <= 1'b0;
            spark_amount_reg   <= '0;
            clearing_frame_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            cell_counter_reg   <= cell_counter_next;
            spark_position_reg <= pos_eff;
            spark_armed_reg    <= armed_eff && !hit;
            spark_amount_reg   <= amt_eff;
            clearing_frame_reg <= clear_eff;
        end
    end

    // Stage 1 valid and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            cooled_above_one_reg <= '0;
            cooled_above_two_reg <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg        <= 1'b1;
                cooled_above_two_reg <= cooled_above_one_reg;
                cooled_above_one_reg <= s1_cooled;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage 1 and output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_idx_reg       <= idx;
            s1_cool_amt_reg  <= cool_amt;
            s1_drift_reg     <= drift;
            s1_hit_reg       <= hit;
            s1_spark_amt_reg <= amt_eff;
            s1_clear_reg     <= clear_eff;
            s1_bypass_reg    <= bypass;
            s1_fwd_reg       <= s1_heat;
        end
        if (s1_fire)
        begin
            out_idx_reg  <= s1_idx_reg;
            out_heat_reg <= s1_heat;
            out_last_reg <= (s1_idx_reg == '0);
        end
    end

    // Palette index from the output register
    logic [15:0] color_prod;

    assign color_prod    = 16'(out_heat_reg) * 16'(COLOR_SCALE);
    assign out_valid     = out_valid_reg;
    assign cell_index    = OUT_IDX_W'(out_idx_reg);
    assign heat_value    = out_heat_reg;
    assign color_index   = color_prod[15:8];
    assign last_of_frame = out_last_reg;

    // Checks
    `LFH_ASSERT(a_sweep_no_pipe, clk, rst_n, sweep_active_reg |-> !s1_valid_reg, "sweep overlaps a pipeline write")
    `LFH_ASSERT(a_clear_after_sweep, clk, rst_n, (in_fire && frame_start && clear_heat) |-> swept_reg, "clear frame taken without a sweep")
    `LFH_ASSERT(a_bound_ready, clk, rst_n, in_fire |-> (bound >= HEAT_W'(BOUND_BIAS)), "cell taken before the bound is computed")
    `LFH_ASSERT_NEXT(a_s1_hold, clk, rst_n, (s1_valid_reg && !s2_take), (s1_valid_reg && $stable(s1_idx_reg)), "stalled stage 1 lost its cell")

endmodule
